// File: rtl/core/fdep_pkg.sv
// ----------------------------------------------------------------------------
// fdep_pkg
// Shared types and constants for the directory entry parser: entry kinds,
// the classified word carried from front to back, and the result word.
// ----------------------------------------------------------------------------
package fdep_pkg;

  localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
  localparam int unsigned ATTR_DIR_BIT  = 4;
  localparam logic [7:0] MARK_DELETED   = 8'hE5;
  localparam logic [7:0] MARK_END       = 8'h00;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_DOT       = 8'h2E;

  localparam int unsigned BASE_CHARS = 8;
  localparam int unsigned EXT_CHARS  = 3;
  localparam int unsigned NAME_CHARS = BASE_CHARS + 1 + EXT_CHARS;

  // Depth of the queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ST_VALID            = 3'd0,
    ST_LONG             = 3'd1,
    ST_SHORT_AFTER_LONG = 3'd2,
    ST_DELETED          = 3'd3,
    ST_END              = 3'd4
  } fdep_status_t;

  // Classified entry as it waits between front and back.
  typedef struct packed {
    fdep_status_t status;
    logic [63:0]  base;
    logic [23:0]  ext;
    logic [7:0]   attr;
    logic [15:0]  cluster;
    logic [39:0]  create;
    logic [15:0]  access;
    logic [31:0]  write;
    logic [31:0]  size;
  } fdep_work_t;

  typedef struct packed {
    fdep_status_t status;
    logic [63:0]  name_low;
    logic [31:0]  name_high;
    logic [3:0]   name_length;
    logic [7:0]   attributes;
    logic [15:0]  first_cluster;
    logic [39:0]  create_stamp;
    logic [15:0]  access_date;
    logic [31:0]  write_stamp;
    logic [31:0]  size_bytes;
  } fdep_result_t;

endpackage

// File: rtl/core/fdep_front.sv
// ----------------------------------------------------------------------------
// fdep_front
// Accept entry words, classify each entry and track the long-name flag.
// ----------------------------------------------------------------------------
module fdep_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [63:0]       entry_word0,
  input  logic [63:0]       entry_word1,
  input  logic [63:0]       entry_word2,
  input  logic [63:0]       entry_word3,
  output fdep_pkg::fdep_work_t work
);
  import fdep_pkg::*;

  logic         after_long_name;
  logic [7:0]   attr;
  logic [7:0]   first;
  fdep_status_t status;

  assign attr  = entry_word1[31:24];
  assign first = entry_word0[7:0];

  // Long-name test wins over the end and deleted marks.
  always_comb begin
    if (attr == ATTR_LONG_NAME) begin
      status = ST_LONG;
    end else if (first == MARK_END) begin
      status = ST_END;
    end else if (first == MARK_DELETED) begin
      status = ST_DELETED;
    end else if (after_long_name) begin
      status = ST_SHORT_AFTER_LONG;
    end else begin
      status = ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      after_long_name <= 1'b0;
    end else if (accept) begin
      after_long_name <= (status == ST_LONG);
    end
  end

  always_comb begin
    work.status  = status;
    work.base    = entry_word0;
    work.ext     = entry_word1[23:0];
    work.attr    = attr;
    work.cluster = entry_word3[31:16];
    work.create  = {entry_word2[15:0], entry_word1[63:48], entry_word1[47:40]};
    work.access  = entry_word2[31:16];
    work.write   = {entry_word3[15:0], entry_word2[63:48]};
    work.size    = entry_word3[63:32];
  end

  a_long_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && status == ST_LONG) |=> after_long_name)
    else $error("long-name entry did not set the flag");

  a_other_clears_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && status != ST_LONG) |=> !after_long_name)
    else $error("flag survived a non long-name entry");

  a_flag_held: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(after_long_name))
    else $error("flag changed without an entry");

endmodule

// File: rtl/core/fdep_queue.sv
// ----------------------------------------------------------------------------
// fdep_queue
// Short queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module fdep_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  fdep_pkg::fdep_work_t wr_data,
  output logic                full,
  input  logic                rd,
  output fdep_pkg::fdep_work_t rd_data,
  output logic                empty
);
  import fdep_pkg::*;

  fdep_work_t        slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> !full)
    else $error("write into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> !empty)
    else $error("read from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

// File: rtl/core/fdep_back.sv
// ----------------------------------------------------------------------------
// fdep_back
// Build the lowered 8.3 name, zero the fields of skipped entries and hold
// the result word in an output register.
// ----------------------------------------------------------------------------
module fdep_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  fdep_pkg::fdep_work_t  work,
  output logic                  q_rd,
  input  logic                  pop,
  output logic                  empty,
  output fdep_pkg::fdep_result_t result
);
  import fdep_pkg::*;

  function automatic logic [7:0] lower_char(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  logic         out_valid;
  logic [3:0]   blen;
  logic [1:0]   elen;
  logic         has_ext;
  logic [7:0]   name_byte [NAME_CHARS];
  fdep_result_t res_next;

  assign q_rd  = !q_empty && (!out_valid || pop);
  assign empty = !out_valid;

  // Base length: up to the first space.
  always_comb begin
    logic found;
    found = 1'b0;
    blen  = 4'(BASE_CHARS);
    for (int i = 0; i < BASE_CHARS; i++) begin
      if (!found && work.base[8*i +: 8] == CHAR_SPACE) begin
        found = 1'b1;
        blen  = 4'(i);
      end
    end
  end

  always_comb begin
    logic found;
    found = 1'b0;
    elen  = 2'(EXT_CHARS);
    for (int i = 0; i < EXT_CHARS; i++) begin
      if (!found && work.ext[8*i +: 8] == CHAR_SPACE) begin
        found = 1'b1;
        elen  = 2'(i);
      end
    end
  end

  assign has_ext = !work.attr[ATTR_DIR_BIT] && (work.ext[7:0] != CHAR_SPACE);

  // Place each output character: base, dot, extension, then zero fill.
  always_comb begin
    logic [3:0] pos;
    logic [3:0] k;
    for (int p = 0; p < NAME_CHARS; p++) begin
      pos = 4'(p);
      k   = pos - blen - 4'd1;
      if (pos < blen) begin
        name_byte[p] = lower_char(work.base[8*pos[2:0] +: 8]);
      end else if (has_ext && pos == blen) begin
        name_byte[p] = CHAR_DOT;
      end else if (has_ext && pos > blen && k < {2'b00, elen}) begin
        case (k[1:0])
          2'd0:    name_byte[p] = lower_char(work.ext[7:0]);
          2'd1:    name_byte[p] = lower_char(work.ext[15:8]);
          default: name_byte[p] = lower_char(work.ext[23:16]);
        endcase
      end else begin
        name_byte[p] = 8'h00;
      end
    end
  end

  always_comb begin
    res_next        = '0;
    res_next.status = work.status;
    if (work.status == ST_VALID) begin
      for (int p = 0; p < BASE_CHARS; p++) begin
        res_next.name_low[8*p +: 8] = name_byte[p];
      end
      for (int p = BASE_CHARS; p < NAME_CHARS; p++) begin
        res_next.name_high[8*(p-BASE_CHARS) +: 8] = name_byte[p];
      end
      res_next.name_length   = blen + (has_ext ? 4'd1 + {2'b00, elen} : 4'd0);
      res_next.attributes    = work.attr;
      res_next.first_cluster = work.cluster;
      res_next.create_stamp  = work.create;
      res_next.access_date   = work.access;
      res_next.write_stamp   = work.write;
      res_next.size_bytes    = work.size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      result <= res_next;
    end
  end

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(result)))
    else $error("stalled result word changed");

  a_skipped_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.status != ST_VALID) |->
      (result.name_length == 4'd0 && result.size_bytes == '0 &&
       result.attributes == '0))
    else $error("skipped entry carries nonzero fields");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result.name_length <= 4'(NAME_CHARS))
    else $error("name length out of range");

endmodule

// File: rtl/core/fat_dir_entry_parser_core.sv
// ----------------------------------------------------------------------------
// fat_dir_entry_parser_core
// FAT short-name directory entry parser, one 32-byte entry per push.
// ----------------------------------------------------------------------------
// Push one directory entry per cycle while full is low, as four little-endian
// 64-bit words, and pop one result word per entry, in order. The front
// classifies the entry (long-name, end of directory, deleted, short entry
// following long-name entries, or valid) and keeps the one-bit long-name
// flag, so it never waits on anything but the queue; a four-deep queue
// decouples it from the back, which builds the lowered 8.3 name and
// registers the result. The block sustains one entry per cycle while pop
// keeps up; a result word passes through the queue and the output register
// before it is on the ports, and full rises only once the back has been
// stalled by pop long enough to fill the queue and the output register.
// Fields of a result whose status is not valid read as zero.
// ----------------------------------------------------------------------------
module fat_dir_entry_parser_core (
  input  logic        clk,
  input  logic        rst,
  // entry side
  input  logic        push,
  output logic        full,
  input  logic [63:0] entry_word0,
  input  logic [63:0] entry_word1,
  input  logic [63:0] entry_word2,
  input  logic [63:0] entry_word3,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  entry_status,
  output logic [63:0] name_low,
  output logic [31:0] name_high,
  output logic [3:0]  name_length,
  output logic [7:0]  attributes,
  output logic [15:0] first_cluster,
  output logic [39:0] create_stamp,
  output logic [15:0] access_date,
  output logic [31:0] write_stamp,
  output logic [31:0] size_bytes
);
  import fdep_pkg::*;

  logic         accept;
  fdep_work_t   front_work;
  fdep_work_t   back_work;
  logic         q_empty;
  logic         q_rd;
  fdep_result_t result;

  // Take the entry words whenever push is high and the queue has room.
  assign accept = push && !full;

  fdep_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .entry_word0 (entry_word0),
    .entry_word1 (entry_word1),
    .entry_word2 (entry_word2),
    .entry_word3 (entry_word3),
    .work        (front_work)
  );

  fdep_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_data (front_work),
    .full    (full),
    .rd      (q_rd),
    .rd_data (back_work),
    .empty   (q_empty)
  );

  fdep_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .work    (back_work),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // Unpack the held result word onto the ports.
  assign entry_status  = result.status;
  assign name_low      = result.name_low;
  assign name_high     = result.name_high;
  assign name_length   = result.name_length;
  assign attributes    = result.attributes;
  assign first_cluster = result.first_cluster;
  assign create_stamp  = result.create_stamp;
  assign access_date   = result.access_date;
  assign write_stamp   = result.write_stamp;
  assign size_bytes    = result.size_bytes;

endmodule

// File: tb/fat_dir_entry_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_dir_entry_parser_core_tb
// Self-checking bench for the FAT short-name directory entry parser. Entry
// words are pushed with random gaps and result words are popped with random
// stalls. A scoreboard predicts each result from its entry and from its own
// copy of the long-name flag, then compares every popped word field by field.
// ----------------------------------------------------------------------------
module fat_dir_entry_parser_core_tb;
  import fdep_pkg::*;

  localparam int unsigned RANDOM_WORDS  = 1500;
  localparam int unsigned DRAIN_EVERY   = 400;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam logic [7:0]  ATTR_DIR      = 8'h01 << ATTR_DIR_BIT;
  localparam logic [7:0]  ATTR_ARCHIVE  = 8'h20;

  // One 32-byte directory entry, byte 0 in bits 7:0 of w0.
  typedef struct packed {
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w2;
    logic [63:0] w3;
  } dir_entry_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predict the result word of each accepted entry word and hold
  // the predictions in order until the matching result is popped.
  // --------------------------------------------------------------------------
  class entry_scoreboard;
    bit           follows_long;
    fdep_result_t pending_results[$];
    int           failures;

    function automatic logic [7:0] fold_case(logic [7:0] c);
      // Lower A to Z only; every other byte passes through untouched.
      return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
    endfunction

    function automatic fdep_result_t parse_entry(dir_entry_t e);
      fdep_result_t r;
      logic [7:0]   attr;
      logic [7:0]   first;
      logic [7:0]   c;
      logic [95:0]  name;
      int           n;
      bit           stop;
      r     = '0;
      attr  = e.w1[31:24];
      first = e.w0[7:0];
      // Long-name test wins over the end and deleted marks.
      if (attr == ATTR_LONG_NAME)
        r.status = ST_LONG;
      else if (first == MARK_END)
        r.status = ST_END;
      else if (first == MARK_DELETED)
        r.status = ST_DELETED;
      else if (follows_long)
        r.status = ST_SHORT_AFTER_LONG;
      else
        r.status = ST_VALID;
      follows_long = (r.status == ST_LONG);
      if (r.status != ST_VALID)
        return r;

      name = '0;
      n    = 0;
      stop = 1'b0;
      for (int i = 0; i < BASE_CHARS; i++) begin
        c = e.w0[8*i +: 8];
        if (c == CHAR_SPACE)
          stop = 1'b1;
        if (!stop) begin
          name[8*n +: 8] = fold_case(c);
          n++;
        end
      end
      if (!attr[ATTR_DIR_BIT] && e.w1[7:0] != CHAR_SPACE) begin
        name[8*n +: 8] = CHAR_DOT;
        n++;
        stop = 1'b0;
        for (int i = 0; i < EXT_CHARS; i++) begin
          c = e.w1[8*i +: 8];
          if (c == CHAR_SPACE)
            stop = 1'b1;
          if (!stop) begin
            name[8*n +: 8] = fold_case(c);
            n++;
          end
        end
      end
      r.name_low      = name[63:0];
      r.name_high     = name[95:64];
      r.name_length   = n[3:0];
      r.attributes    = attr;
      r.first_cluster = e.w3[31:16];
      r.create_stamp  = {e.w2[15:0], e.w1[63:48], e.w1[47:40]};
      r.access_date   = e.w2[31:16];
      r.write_stamp   = {e.w3[15:0], e.w2[63:48]};
      r.size_bytes    = e.w3[63:32];
      return r;
    endfunction

    function void note_entry(dir_entry_t e);
      pending_results.push_back(parse_entry(e));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        failures++;
        $error("%s: expected %h, got %h", field, want, got);
      end
    endfunction

    function void check_result(fdep_result_t got);
      fdep_result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        $error("result word popped with nothing expected (status %0d)", got.status);
        return;
      end
      want = pending_results.pop_front();
      compare_field("entry_status",  want.status,        got.status);
      compare_field("name_low",      want.name_low,      got.name_low);
      compare_field("name_high",     want.name_high,     got.name_high);
      compare_field("name_length",   want.name_length,   got.name_length);
      compare_field("attributes",    want.attributes,    got.attributes);
      compare_field("first_cluster", want.first_cluster, got.first_cluster);
      compare_field("create_stamp",  want.create_stamp,  got.create_stamp);
      compare_field("access_date",   want.access_date,   got.access_date);
      compare_field("write_stamp",   want.write_stamp,   got.write_stamp);
      compare_field("size_bytes",    want.size_bytes,    got.size_bytes);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] entry_word0 = '0;
  logic [63:0] entry_word1 = '0;
  logic [63:0] entry_word2 = '0;
  logic [63:0] entry_word3 = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  entry_status;
  logic [63:0] name_low;
  logic [31:0] name_high;
  logic [3:0]  name_length;
  logic [7:0]  attributes;
  logic [15:0] first_cluster;
  logic [39:0] create_stamp;
  logic [15:0] access_date;
  logic [31:0] write_stamp;
  logic [31:0] size_bytes;

  entry_scoreboard sb = new();

  always #5 clk = ~clk;

  fat_dir_entry_parser_core dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .entry_word0   (entry_word0),
    .entry_word1   (entry_word1),
    .entry_word2   (entry_word2),
    .entry_word3   (entry_word3),
    .empty         (empty),
    .pop           (pop),
    .entry_status  (entry_status),
    .name_low      (name_low),
    .name_high     (name_high),
    .name_length   (name_length),
    .attributes    (attributes),
    .first_cluster (first_cluster),
    .create_stamp  (create_stamp),
    .access_date   (access_date),
    .write_stamp   (write_stamp),
    .size_bytes    (size_bytes)
  );

  // --------------------------------------------------------------------------
  // Watchdog: abort if neither side moves a word for too long.
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Entry builders
  // --------------------------------------------------------------------------
  // Pack text into name bytes, first character lowest, padded with spaces.
  function automatic logic [63:0] spell(string s);
    logic [63:0] w;
    for (int i = 0; i < 8; i++)
      w[8*i +: 8] = (i < s.len()) ? s[i] : CHAR_SPACE;
    return w;
  endfunction

  // Same packing for the three extension bytes.
  function automatic logic [23:0] spell_ext(string s);
    logic [63:0] w;
    w = spell(s);
    return w[23:0];
  endfunction

  // Put base, extension and attribute in place; fill the stamps at random.
  function automatic dir_entry_t build_entry(logic [63:0] base, logic [23:0] ext,
                                             logic [7:0] attr);
    dir_entry_t e;
    e.w0 = base;
    e.w1 = {$urandom(), attr, ext};
    e.w2 = {$urandom(), $urandom()};
    e.w3 = {$urandom(), $urandom()};
    return e;
  endfunction

  // Mostly upper-case letters and digits, now and then any printable or any byte.
  function automatic logic [7:0] random_name_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 8'($urandom_range("A", "Z"));
    if (pick < 80) return 8'($urandom_range("0", "9"));
    if (pick < 93) return 8'($urandom_range(8'h21, 8'h7E));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic dir_entry_t random_entry();
    dir_entry_t  e;
    logic [63:0] base;
    logic [23:0] ext;
    logic [7:0]  attr;
    int          kind;
    int          len;
    kind = $urandom_range(0, 99);
    base = spell("");
    ext  = 24'h202020;
    // Well-formed short entry: random-length name padded with spaces.
    len = $urandom_range(0, BASE_CHARS);
    for (int i = 0; i < len; i++)
      base[8*i +: 8] = random_name_char();
    len = $urandom_range(0, EXT_CHARS);
    for (int i = 0; i < len; i++)
      ext[8*i +: 8] = random_name_char();
    attr = 8'($urandom());
    if (attr == ATTR_LONG_NAME)
      attr = ATTR_ARCHIVE;
    e = build_entry(base, ext, attr);
    if (kind < 20) begin
      e.w1[31:24] = ATTR_LONG_NAME;
      if (kind < 8)
        e.w0 = {$urandom(), $urandom()};
    end else if (kind < 25) begin
      e.w0[7:0] = MARK_END;
    end else if (kind < 32) begin
      e.w0[7:0] = MARK_DELETED;
    end else if (kind < 47) begin
      // Raw noise: every bit of every word flips freely.
      e.w0 = {$urandom(), $urandom()};
      e.w1 = {$urandom(), $urandom()};
    end
    return e;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one entry word per call, with a random gap ahead of it.
  // --------------------------------------------------------------------------
  bit push_steady = 1'b0;

  task automatic send_entry(dir_entry_t e);
    int gap;
    if ($urandom_range(0, 39) == 0)
      push_steady = !push_steady;
    gap = push_steady ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push        <= 1'b1;
    entry_word0 <= e.w0;
    entry_word1 <= e.w1;
    entry_word2 <= e.w2;
    entry_word3 <= e.w3;
    // Hold the word until the block takes it.
    do @(posedge clk); while (full);
    sb.note_entry(e);
  endtask

  // Drop push and hold off until every expected result word is back.
  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: pop with random stalls, check every word taken.
  // --------------------------------------------------------------------------
  bit pop_steady = 1'b0;

  initial begin
    fdep_result_t got;
    int           gap;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0)
        pop_steady = !pop_steady;
      gap = pop_steady ? 0 : $urandom_range(0, 9);
      @(negedge clk);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got.status        = fdep_status_t'(entry_status);
      got.name_low      = name_low;
      got.name_high     = name_high;
      got.name_length   = name_length;
      got.attributes    = attributes;
      got.first_cluster = first_cluster;
      got.create_stamp  = create_stamp;
      got.access_date   = access_date;
      got.write_stamp   = write_stamp;
      got.size_bytes    = size_bytes;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    dir_entry_t directed[$];
    dir_entry_t e;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Plain names, full-width names, directory, blank and split extensions.
    directed.push_back(build_entry(spell("README"), spell_ext("TXT"), ATTR_ARCHIVE));
    directed.push_back(build_entry(spell("ABCDEFGH"), spell_ext("XYZ"), 8'h00));
    directed.push_back(build_entry(spell("SUBDIR"), spell_ext("EXT"), ATTR_DIR));
    directed.push_back(build_entry(spell("NOEXT"), spell_ext(""), ATTR_ARCHIVE));
    directed.push_back(build_entry(spell("A"), spell_ext("B C"), ATTR_ARCHIVE));
    // Case-folding edges: just outside and at both ends of A to Z.
    directed.push_back(build_entry(spell("@AZ[\140az{"), spell_ext("0_9"), 8'h01));
    // Zero bytes inside the name are kept and counted.
    directed.push_back(build_entry(64'h41, 24'h0, ATTR_ARCHIVE));
    // Blank base, extension only.
    directed.push_back(build_entry(spell(""), spell_ext("TXT"), ATTR_ARCHIVE));
    // Leading byte 0x05 is an ordinary character here.
    directed.push_back(build_entry(spell("\005KANJI"), spell_ext("DAT"), ATTR_ARCHIVE));
    // All-ones entry: valid, directory bit set, name of 0xFF bytes.
    directed.push_back('1);
    // All-zero entry: end of directory.
    directed.push_back('0);
    // Long-name wins over the end and deleted marks; flag set then cleared.
    directed.push_back(build_entry({56'h0, MARK_END}, 24'h0, ATTR_LONG_NAME));
    directed.push_back(build_entry(spell("SKIPPED"), spell_ext("TXT"), ATTR_ARCHIVE));
    directed.push_back(build_entry({56'h0, MARK_DELETED}, 24'h0, ATTR_LONG_NAME));
    directed.push_back(build_entry(spell("LONG"), spell_ext("TWO"), ATTR_LONG_NAME));
    directed.push_back(build_entry(spell("LONG"), spell_ext("ONE"), ATTR_LONG_NAME));
    directed.push_back(build_entry(spell("ANOTHER"), spell_ext("SKP"), ATTR_DIR));
    directed.push_back(build_entry(spell(""), spell_ext(""), ATTR_LONG_NAME));
    directed.push_back(build_entry({56'h0, MARK_END}, spell_ext("BIN"), ATTR_ARCHIVE));
    directed.push_back(build_entry(spell("AFTEREND"), spell_ext("OK"), ATTR_ARCHIVE));
    directed.push_back(build_entry(spell("X"), spell_ext("Y"), ATTR_LONG_NAME));
    directed.push_back(build_entry({56'(spell("ONE")), MARK_DELETED}, spell_ext("TMP"),
                                   8'h00));
    directed.push_back(build_entry(spell("VISIBLE"), spell_ext("C"), ATTR_ARCHIVE));
    // Stamps at both extremes on a valid entry.
    e = build_entry(spell("ZERO"), spell_ext("STM"), ATTR_ARCHIVE);
    e.w1[63:32] = '0;
    e.w2 = '0;
    e.w3 = '0;
    directed.push_back(e);
    e.w1[63:32] = '1;
    e.w2 = '1;
    e.w3 = '1;
    directed.push_back(e);

    foreach (directed[i])
      send_entry(directed[i]);
    drain_results();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      send_entry(random_entry());
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
        drain_results();
    end

    // Let the last words out and watch for anything extra.
    drain_results();
    repeat (8) @(posedge clk);
    if (sb.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
